// ===== rtl/mtcr_pkg.sv =====
`default_nettype none
package mtcr_pkg;

  // Characters with a meaning of their own in the string.
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Lengths of the words that are matched.
  localparam logic [3:0] TYPE_LEN = 4'd10;
  localparam logic [3:0] NAME_LEN = 4'd7;
  localparam logic [3:0] DASH_LEN = 4'd5;
  localparam logic [3:0] BARE_LEN = 4'd4;

  // Rank codes.
  localparam logic [1:0] RANK_OTHER = 2'd0;
  localparam logic [1:0] RANK_PLAIN = 2'd1;
  localparam logic [1:0] RANK_UTF8  = 2'd2;

  // One registered input request.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } mtcr_item_t;

  // Lower-case only the letters A to Z.
  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // "text/plain"
  function automatic logic [7:0] type_char(input logic [3:0] pos);
    case (pos)
      4'd0:    type_char = 8'h74;
      4'd1:    type_char = 8'h65;
      4'd2:    type_char = 8'h78;
      4'd3:    type_char = 8'h74;
      4'd4:    type_char = 8'h2F;
      4'd5:    type_char = 8'h70;
      4'd6:    type_char = 8'h6C;
      4'd7:    type_char = 8'h61;
      4'd8:    type_char = 8'h69;
      4'd9:    type_char = 8'h6E;
      default: type_char = 8'h00;
    endcase
  endfunction

  // "charset"
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    case (pos)
      4'd0:    name_char = 8'h63;
      4'd1:    name_char = 8'h68;
      4'd2:    name_char = 8'h61;
      4'd3:    name_char = 8'h72;
      4'd4:    name_char = 8'h73;
      4'd5:    name_char = 8'h65;
      4'd6:    name_char = 8'h74;
      default: name_char = 8'h00;
    endcase
  endfunction

  // "utf-8"
  function automatic logic [7:0] dash_char(input logic [3:0] pos);
    case (pos)
      4'd0:    dash_char = 8'h75;
      4'd1:    dash_char = 8'h74;
      4'd2:    dash_char = 8'h66;
      4'd3:    dash_char = 8'h2D;
      4'd4:    dash_char = 8'h38;
      default: dash_char = 8'h00;
    endcase
  endfunction

  // "utf8"
  function automatic logic [7:0] bare_char(input logic [3:0] pos);
    case (pos)
      4'd0:    bare_char = 8'h75;
      4'd1:    bare_char = 8'h74;
      4'd2:    bare_char = 8'h66;
      4'd3:    bare_char = 8'h38;
      default: bare_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mtcr_input_stage.sv =====
`default_nettype none
module mtcr_input_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          char_byte,
  input  wire logic                end_of_string,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                advance,
  output logic                     item_valid,
  output mtcr_pkg::mtcr_item_t     item
);
  import mtcr_pkg::*;

  // The register takes a new request when it is empty or is being drained.
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.char_byte <= char_byte;
      item.last      <= end_of_string;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mtcr_parser.sv =====
`default_nettype none
module mtcr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire mtcr_pkg::mtcr_item_t item,
  output logic [1:0]                rank
);
  import mtcr_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_NAME  = 3'd1,
    PH_VALUE = 3'd2,
    PH_SKIP  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] match_position, match_position_next;
  logic       still_matching, still_matching_next;
  logic       trailing_blank, trailing_blank_next;
  logic       opened_quote, opened_quote_next;
  logic       closed_quote, closed_quote_next;
  logic [1:0] utf_flags, utf_flags_next;
  logic [1:0] decided_rank, decided_rank_next;

  logic [7:0] c;
  logic [7:0] fc;
  logic       blank;
  logic [3:0] pos_bumped;
  logic       type_done;
  logic       name_done;
  logic [1:0] value_rank_now;
  logic [1:0] value_rank_next;

  assign c          = item.char_byte;
  assign fc         = fold(item.char_byte);
  assign blank      = is_blank(item.char_byte);
  assign pos_bumped = (match_position == 4'hF) ? match_position : match_position + 4'd1;
  assign type_done  = still_matching && (match_position == TYPE_LEN);
  assign name_done  = still_matching && (match_position == NAME_LEN);

  // A value ranks as UTF-8 when one spelling survived to its full length and
  // the quotes, if any, are balanced.
  function automatic logic [1:0] value_rank(input logic [1:0] flags, input logic [3:0] pos,
                                            input logic opened, input logic closed);
    logic hit;
    hit = (flags[0] && pos == DASH_LEN) || (flags[1] && pos == BARE_LEN);
    value_rank = (hit && opened == closed) ? RANK_UTF8 : RANK_OTHER;
  endfunction

  assign value_rank_now = value_rank(utf_flags, match_position, opened_quote, closed_quote);

  // Per-byte state update.
  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    still_matching_next = still_matching;
    trailing_blank_next = trailing_blank;
    opened_quote_next   = opened_quote;
    closed_quote_next   = closed_quote;
    utf_flags_next      = utf_flags;
    decided_rank_next   = decided_rank;

    case (phase)
      PH_TYPE: begin
        if (c == CH_SEMI) begin
          if (type_done) begin
            phase_next          = PH_NAME;
            match_position_next = 4'd0;
            still_matching_next = 1'b1;
            trailing_blank_next = 1'b0;
          end else begin
            decided_rank_next = RANK_OTHER;
            phase_next        = PH_DONE;
          end
        end else if (blank) begin
          if (match_position != 4'd0) trailing_blank_next = 1'b1;
        end else if (trailing_blank || match_position >= TYPE_LEN ||
                     fc != type_char(match_position)) begin
          still_matching_next = 1'b0;
        end else begin
          match_position_next = pos_bumped;
        end
      end

      PH_NAME: begin
        if (c == CH_SEMI) begin
          match_position_next = 4'd0;
          still_matching_next = 1'b1;
          trailing_blank_next = 1'b0;
        end else if (c == CH_EQ) begin
          if (name_done) begin
            phase_next          = PH_VALUE;
            match_position_next = 4'd0;
            still_matching_next = 1'b1;
            trailing_blank_next = 1'b0;
            opened_quote_next   = 1'b0;
            closed_quote_next   = 1'b0;
            utf_flags_next      = 2'b11;
          end else begin
            phase_next = PH_SKIP;
          end
        end else if (blank) begin
          if (match_position != 4'd0) trailing_blank_next = 1'b1;
        end else if (trailing_blank || match_position >= NAME_LEN ||
                     fc != name_char(match_position)) begin
          still_matching_next = 1'b0;
        end else begin
          match_position_next = pos_bumped;
        end
      end

      PH_VALUE: begin
        if (c == CH_SEMI) begin
          decided_rank_next = value_rank_now;
          phase_next        = PH_DONE;
        end else if (blank) begin
          // Leading blanks are dropped; a blank inside quotes spoils the value.
          if (match_position == 4'd0 && !opened_quote) begin
            trailing_blank_next = trailing_blank;
          end else if (opened_quote && !closed_quote) begin
            utf_flags_next = 2'b00;
          end else begin
            trailing_blank_next = 1'b1;
          end
        end else if (trailing_blank || closed_quote) begin
          utf_flags_next = 2'b00;
        end else if (match_position == 4'd0 && !opened_quote && c == CH_QUOTE) begin
          opened_quote_next = 1'b1;
        end else if (opened_quote && c == CH_QUOTE) begin
          closed_quote_next = 1'b1;
        end else begin
          if (match_position >= DASH_LEN || fc != dash_char(match_position)) begin
            utf_flags_next[0] = 1'b0;
          end
          if (match_position >= BARE_LEN || fc != bare_char(match_position)) begin
            utf_flags_next[1] = 1'b0;
          end
          match_position_next = pos_bumped;
        end
      end

      PH_SKIP: begin
        if (c == CH_SEMI) begin
          phase_next          = PH_NAME;
          match_position_next = 4'd0;
          still_matching_next = 1'b1;
          trailing_blank_next = 1'b0;
          opened_quote_next   = 1'b0;
          closed_quote_next   = 1'b0;
          utf_flags_next      = 2'b11;
        end
      end

      default: begin
      end
    endcase
  end

  assign value_rank_next = value_rank(utf_flags_next, match_position_next,
                                      opened_quote_next, closed_quote_next);

  // Rank of the string if this byte is its last one.
  always_comb begin
    case (phase_next)
      PH_TYPE: begin
        rank = (still_matching_next && match_position_next == TYPE_LEN) ? RANK_PLAIN
                                                                         : RANK_OTHER;
      end
      PH_NAME:  rank = RANK_PLAIN;
      PH_SKIP:  rank = RANK_PLAIN;
      PH_VALUE: rank = value_rank_next;
      default:  rank = decided_rank_next;
    endcase
  end

  // State registers; the last byte of a string returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      phase          <= PH_TYPE;
      match_position <= 4'd0;
      still_matching <= 1'b1;
      trailing_blank <= 1'b0;
      opened_quote   <= 1'b0;
      closed_quote   <= 1'b0;
      utf_flags      <= 2'b11;
      decided_rank   <= RANK_PLAIN;
    end else if (step) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      still_matching <= still_matching_next;
      trailing_blank <= trailing_blank_next;
      opened_quote   <= opened_quote_next;
      closed_quote   <= closed_quote_next;
      utf_flags      <= utf_flags_next;
      decided_rank   <= decided_rank_next;
    end
  end

  // A finished string leaves the parser at the start of a type.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.last |=> phase == PH_TYPE && match_position == 4'd0 && utf_flags == 2'b11)
    else $error("parser did not restart after the last byte");

  // A decided string stays decided until its last byte.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    step && !item.last && phase == PH_DONE |=> phase == PH_DONE && $stable(decided_rank))
    else $error("decided rank changed before the end of the string");

  // The type match never runs past the length of its word.
  a_type_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TYPE |-> match_position <= TYPE_LEN)
    else $error("type match position out of range");

  // Quotes close only after they open.
  a_quotes: assert property (@(posedge clk) disable iff (rst)
    closed_quote |-> opened_quote)
    else $error("closing quote without an opening one");

endmodule
`default_nettype wire

// ===== rtl/mime_text_charset_ranker.sv =====
`default_nettype none
// Channel   Signals                                     Direction
// input     in_valid, in_ready, char_byte, end_of_string   in
// result    out_valid, out_ready, rank                     out
//
// Each byte request is held in the input register and parsed there; a byte
// flagged last loads the rank into the result register when it moves on, so the
// rank passes through the input register and then the result register.
// One byte is accepted per cycle unless a stall holds it; the parser state update is the only loop.
// Reset is synchronous and returns the parser to the start of a type.
// A waiting rank stalls only a last byte and the bytes behind it; other bytes keep flowing.
module mime_text_charset_ranker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_string,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [1:0]      rank,
  output logic            out_valid,
  input  wire logic       out_ready
);
  import mtcr_pkg::*;

  logic       item_valid;
  mtcr_item_t item;
  logic       advance;
  logic       load_rank;
  logic [1:0] parsed_rank;

  // A byte moves on unless it must write a rank that cannot be held yet.
  assign advance   = item_valid && (!item.last || !out_valid || out_ready);
  assign load_rank = advance && item.last;

  mtcr_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .char_byte     (char_byte),
    .end_of_string (end_of_string),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  mtcr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .rank (parsed_rank)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_rank) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rank) begin
      rank <= parsed_rank;
    end
  end

  // Only the three defined ranks are ever delivered.
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rank != 2'd3)
    else $error("undefined rank delivered");

  // A held rank is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load_rank)
    else $error("rank overwritten while waiting");

  // Every last byte that moves on produces a rank in the next cycle.
  a_rank_follows: assert property (@(posedge clk) disable iff (rst)
    load_rank |=> out_valid)
    else $error("rank missing after the last byte");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mtcr_pkg::*;

  localparam int CLOCK_LIMIT = 400000;
  localparam int STREAM_BYTES = 1200;
  localparam int LONG_HOLD = 400;

  // Phases of the parse, one per kind of segment in the string.
  typedef enum logic [2:0] {
    SEG_TYPE,
    SEG_NAME,
    SEG_VALUE,
    SEG_SKIP,
    SEG_DONE
  } seg_t;

  // Tracks the parse of the current string and holds the ranks still owed by the block.
  class rank_ledger;
    string type_word = "text/plain";
    string name_word = "charset";
    string dash_word = "utf-8";
    string bare_word = "utf8";

    seg_t       phase;
    logic [3:0] pos;
    bit         still_matching;
    bit         blank_after;
    bit         opened_q;
    bit         closed_q;
    logic [1:0] utf_alive;
    logic [1:0] decided;

    logic [1:0] due_ranks[$];
    int         mismatches;
    int         ranks_seen;

    function new();
      restart();
    endfunction

    function void clear_segment();
      pos = '0;
      still_matching = 1'b1;
      blank_after = 1'b0;
      opened_q = 1'b0;
      closed_q = 1'b0;
      utf_alive = 2'b11;
    endfunction

    function void restart();
      phase = SEG_TYPE;
      clear_segment();
      decided = RANK_PLAIN;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function void step_pos();
      if (pos != 4'd15) pos++;
    endfunction

    // A word may be surrounded by blanks, but a blank inside it breaks the match.
    function void feed_word(logic [7:0] c, string word, logic [3:0] len);
      if (blank(c)) begin
        if (pos != 0) blank_after = 1'b1;
        return;
      end
      if (blank_after || pos >= len || lower(c) != word[pos]) still_matching = 1'b0;
      else step_pos();
    endfunction

    function bit word_done(logic [3:0] len);
      return still_matching && pos == len;
    endfunction

    // The charset value may sit inside one pair of quotes; blanks inside quotes spoil it.
    function void feed_value(logic [7:0] c);
      logic [7:0] f;
      if (blank(c)) begin
        if (pos == 0 && !opened_q) return;
        if (opened_q && !closed_q) utf_alive = 2'b00;
        else blank_after = 1'b1;
        return;
      end
      if (blank_after || closed_q) begin
        utf_alive = 2'b00;
      end else if (pos == 0 && !opened_q && c == CH_QUOTE) begin
        opened_q = 1'b1;
      end else if (opened_q && c == CH_QUOTE) begin
        closed_q = 1'b1;
      end else begin
        f = lower(c);
        if (pos >= DASH_LEN || f != dash_word[pos]) utf_alive[0] = 1'b0;
        if (pos >= BARE_LEN || f != bare_word[pos]) utf_alive[1] = 1'b0;
        step_pos();
      end
    endfunction

    function logic [1:0] value_rank();
      bit hit;
      hit = (utf_alive[0] && pos == DASH_LEN) || (utf_alive[1] && pos == BARE_LEN);
      return (hit && opened_q == closed_q) ? RANK_UTF8 : RANK_OTHER;
    endfunction

    // Called for every accepted byte request; a last byte queues the rank it implies.
    function void note_byte(logic [7:0] c, logic last);
      logic [1:0] r;
      case (phase)
        SEG_TYPE: begin
          if (c == CH_SEMI) begin
            if (word_done(TYPE_LEN)) begin
              phase = SEG_NAME;
              clear_segment();
            end else begin
              decided = RANK_OTHER;
              phase = SEG_DONE;
            end
          end else begin
            feed_word(c, type_word, TYPE_LEN);
          end
        end
        SEG_NAME: begin
          if (c == CH_SEMI) begin
            clear_segment();
          end else if (c == CH_EQ) begin
            if (word_done(NAME_LEN)) begin
              phase = SEG_VALUE;
              clear_segment();
            end else begin
              phase = SEG_SKIP;
            end
          end else begin
            feed_word(c, name_word, NAME_LEN);
          end
        end
        SEG_VALUE: begin
          if (c == CH_SEMI) begin
            decided = value_rank();
            phase = SEG_DONE;
          end else begin
            feed_value(c);
          end
        end
        SEG_SKIP: begin
          if (c == CH_SEMI) begin
            phase = SEG_NAME;
            clear_segment();
          end
        end
        default: ;
      endcase

      if (last) begin
        case (phase)
          SEG_TYPE:           r = word_done(TYPE_LEN) ? RANK_PLAIN : RANK_OTHER;
          SEG_NAME, SEG_SKIP: r = RANK_PLAIN;
          SEG_VALUE:          r = value_rank();
          default:            r = decided;
        endcase
        due_ranks.push_back(r);
        restart();
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_rank(logic [1:0] r);
      logic [1:0] want;
      ranks_seen++;
      if (due_ranks.size() == 0) begin
        report($sformatf("rank %0d came out with no string outstanding", r));
        return;
      end
      want = due_ranks.pop_front();
      if (r !== want) report($sformatf("rank %0d, expected %0d", r, want));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] rank;
  logic       out_valid;
  logic       out_ready = 1'b0;

  rank_ledger ledger = new();
  logic [7:0] pending[$];
  bit         in_quiet;
  bit         long_hold_done;
  int         cycles;

  string odd_types[$] = '{"text/html", "text/plai", "text/plainn", "text/pla in",
                          "image/png", "text", "xtext/plain", "t"};
  string odd_names[$] = '{"format", "charse", "charsets", "char set", "x", "", "utf-8"};
  string value_pool[$] = '{"utf-8", "utf8", "utf-8", "utf8", "utf-16", "utf-", "utf 8",
                           "us-ascii", "utf-88", "utf", "", "8"};

  mime_text_charset_ranker DUT (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (char_byte),
    .end_of_string(end_of_string),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rank         (rank),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CLOCK_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Every rank that leaves the block is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.check_rank(rank);
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_text(string w, bit mix);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (mix && c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 2) == 0) c -= 8'd32;
      pending.push_back(c);
    end
  endfunction

  function automatic void put_blanks();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) pending.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
  endfunction

  // Random bytes, weighted toward the characters that steer the parse.
  function automatic void put_noise(int n);
    logic [7:0] marks[5];
    marks = '{CH_SEMI, CH_EQ, CH_QUOTE, CH_SPACE, CH_TAB};
    repeat (n) begin
      if ($urandom_range(0, 9) < 3) pending.push_back(marks[$urandom_range(0, 4)]);
      else pending.push_back($urandom_range(0, 255));
    end
  endfunction

  // Mostly well-formed type strings with random case, blanks, quoting and parameters.
  function automatic void build_string();
    bit quoted;
    pending.delete();
    if ($urandom_range(0, 6) == 0) begin
      put_noise($urandom_range(1, 10));
    end else begin
      put_blanks();
      put_text(($urandom_range(0, 3) != 0) ? "text/plain"
               : odd_types[$urandom_range(0, odd_types.size() - 1)], 1'b1);
      put_blanks();
      repeat ($urandom_range(0, 3)) begin
        pending.push_back(CH_SEMI);
        put_blanks();
        put_text(($urandom_range(0, 3) != 0) ? "charset"
                 : odd_names[$urandom_range(0, odd_names.size() - 1)], 1'b1);
        put_blanks();
        if ($urandom_range(0, 9) != 0) pending.push_back(CH_EQ);
        put_blanks();
        quoted = ($urandom_range(0, 9) < 3);
        if (quoted) pending.push_back(CH_QUOTE);
        put_text(value_pool[$urandom_range(0, value_pool.size() - 1)], 1'b1);
        if (quoted ? ($urandom_range(0, 19) < 17) : ($urandom_range(0, 19) < 2))
          pending.push_back(CH_QUOTE);
        put_blanks();
      end
      // Random junk may trail the parameters.
      if ($urandom_range(0, 6) == 0) put_noise($urandom_range(1, 6));
      if ($urandom_range(0, 11) == 0 && pending.size() > 0)
        pending[$urandom_range(0, pending.size() - 1)] = $urandom_range(0, 255);
    end
    if (pending.size() == 0) pending.push_back($urandom_range(0, 255));
  endfunction

  // Entered and left at a falling edge; valid stays up across back-to-back requests.
  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    gap = idle_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_byte <= c;
    end_of_string <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_byte(c, last);
    @(negedge clk);
  endtask

  task automatic send_pending();
    in_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pending.size(); i++) send_byte(pending[i], i == pending.size() - 1);
  endtask

  // Result side: runs of ready broken by stalls, plus one long hold-off to back up the input.
  initial begin : result_sink
    int stall;
    int held;
    bit quiet;
    repeat (9) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 10)) @(negedge clk);
      if (!long_hold_done && ledger.ranks_seen >= 4) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(negedge clk);
          held++;
        end
      end else begin
        stall = idle_gap(quiet);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // Request side and end of run.
  initial begin : request_source
    int sent;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings: a high byte alone, a lone separator, and a plain UTF-8 type.
    pending = '{8'hFF};
    send_pending();
    pending = '{CH_SEMI};
    send_pending();
    pending.delete();
    put_text("text/plain;charset=utf8", 1'b0);
    send_pending();

    sent = 0;
    while (sent < STREAM_BYTES) begin
      build_string();
      sent += pending.size();
      send_pending();
    end
    in_valid <= 1'b0;

    while (ledger.due_ranks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mtcr_pkg.sv
rtl/mtcr_input_stage.sv
rtl/mtcr_parser.sv
rtl/mime_text_charset_ranker.sv
bench/tb_top.sv
